FILE: src/ftrc_pkg.sv
package ftrc_pkg;

    localparam int MAX_LEVELS  = 4;
    localparam int DIGIT_BITS  = 8;
    localparam int LCA_W       = $clog2(MAX_LEVELS);
    localparam int MAX_CANDS   = 32;
    localparam int PORT_MAX    = 63;
    localparam int PORT_W      = 6;
    localparam int COUNT_W     = 6;
    localparam int IDX_W       = $clog2(MAX_CANDS);
    localparam int HOP_W       = 4;
    localparam int BASE_W      = 15;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int MIX_ROUNDS  = 7;
    localparam int MOD_BITS    = 8;
    localparam int MOD_STEPS   = 32 / MOD_BITS;

    localparam logic [31:0] HASH_INIT = 32'hdeadbeef + (32'd2 << 2);
    localparam logic [4:0]  HASH_ROT [0:MIX_ROUNDS-1] = '{
        5'd14, 5'd11, 5'd25, 5'd16, 5'd4, 5'd14, 5'd24
    };

    typedef enum logic [2:0] {
        CFG_ROUTER_LEVEL       = 3'd0,
        CFG_LEVEL_COUNT        = 3'd1,
        CFG_DOWN_PORT_COUNT    = 3'd2,
        CFG_UP_PORT_COUNT      = 3'd3,
        CFG_PORTS_PER_TERMINAL = 3'd4,
        CFG_EARLY_TURN         = 3'd5,
        CFG_UP_SELECTION       = 3'd6,
        CFG_HASH_SEED          = 3'd7
    } t_cfg_reg;

    typedef struct packed {
        logic [2:0]  router_level;
        logic [3:0]  level_count;
        logic [5:0]  down_port_count;
        logic [5:0]  up_port_count;
        logic [5:0]  ports_per_terminal;
        logic        early_turn;
        logic        up_selection;
        logic [31:0] hash_seed;
    } t_cfg;

    typedef enum logic {
        K_RANGE = 1'b0,
        K_HASH  = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [BASE_W-1:0]  base;
        logic [COUNT_W-1:0] count;
        logic [HOP_W-1:0]   hops;
        logic [31:0]        src_id;
        logic [31:0]        dst_id;
    } t_cmd;

    typedef struct packed {
        logic        start;
        logic [31:0] src_id;
        logic [31:0] dst_id;
    } t_hash_req;

    typedef struct packed {
        logic              done;
        logic [PORT_W-1:0] rem;
    } t_hash_rsp;

    typedef enum logic [1:0] {
        B_IDLE,
        B_EMIT,
        B_HASH
    } t_back_state;

    typedef enum logic [1:0] {
        H_IDLE,
        H_LOAD,
        H_MIX,
        H_MOD
    } t_hash_state;

endpackage

FILE: src/fat_tree_route_candidates.sv
// Route candidate generator for one fat-tree router. A packet head is taken
// whenever busy is low; busy rises only when the four-entry command queue is
// full. Candidates leave on o_valid one per cycle with no way to hold them off, so a
// head with N candidates (up to 32) sends them back to back as one burst. With hash
// selection the single up port comes from a shared hash/modulo unit: the seed loads as
// the head leaves the queue, then a load step, 7 mix rounds and the modulo steps at 8
// quotient bits each follow. Heads that yield no candidate are accepted and dropped.
// Write configuration only while no candidates are pending.
module fat_tree_route_candidates (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [5:0]  i_arrival_port,
    input  logic [31:0] i_src_digits,
    input  logic [31:0] i_dst_digits,
    input  logic [31:0] i_src_id,
    input  logic [31:0] i_dst_id,
    output logic        o_valid,
    output logic [5:0]  o_out_port,
    output logic [3:0]  o_hop_count,
    output logic        o_last_candidate,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    ftrc_pkg::t_cfg      r_cfg;
    ftrc_pkg::t_cmd      w_push_cmd;
    ftrc_pkg::t_cmd      w_head;
    ftrc_pkg::t_hash_req w_hash_req;
    ftrc_pkg::t_hash_rsp w_hash_rsp;
    logic                w_push;
    logic                w_pop;
    logic                w_full;
    logic                w_empty;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.router_level       <= 3'd0;
            r_cfg.level_count        <= 4'd2;
            r_cfg.down_port_count    <= 6'd4;
            r_cfg.up_port_count      <= 6'd4;
            r_cfg.ports_per_terminal <= 6'd1;
            r_cfg.early_turn         <= 1'b1;
            r_cfg.up_selection       <= 1'b0;
            r_cfg.hash_seed          <= 32'd0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (ftrc_pkg::t_cfg_reg'(i_cfg_index))
                ftrc_pkg::CFG_ROUTER_LEVEL:       r_cfg.router_level       <= i_cfg_data[2:0];
                ftrc_pkg::CFG_LEVEL_COUNT:        r_cfg.level_count        <= i_cfg_data[3:0];
                ftrc_pkg::CFG_DOWN_PORT_COUNT:    r_cfg.down_port_count    <= i_cfg_data[5:0];
                ftrc_pkg::CFG_UP_PORT_COUNT:      r_cfg.up_port_count      <= i_cfg_data[5:0];
                ftrc_pkg::CFG_PORTS_PER_TERMINAL: r_cfg.ports_per_terminal <= i_cfg_data[5:0];
                ftrc_pkg::CFG_EARLY_TURN:         r_cfg.early_turn         <= i_cfg_data[0];
                ftrc_pkg::CFG_UP_SELECTION:       r_cfg.up_selection       <= i_cfg_data[0];
                ftrc_pkg::CFG_HASH_SEED:          r_cfg.hash_seed          <= i_cfg_data;
                default:                          r_cfg.hash_seed          <= r_cfg.hash_seed;
            endcase
        end
    end

    ftrc_front u_front (
        .i_cfg          (r_cfg),
        .i_start        (start),
        .i_full         (w_full),
        .i_arrival_port (i_arrival_port),
        .i_src_digits   (i_src_digits),
        .i_dst_digits   (i_dst_digits),
        .i_src_id       (i_src_id),
        .i_dst_id       (i_dst_id),
        .o_busy         (busy),
        .o_push         (w_push),
        .o_cmd          (w_push_cmd)
    );

    ftrc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_cmd),
        .i_pop   (w_pop),
        .o_data  (w_head),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    ftrc_hash u_hash (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (w_hash_req),
        .i_seed    (r_cfg.hash_seed),
        .i_divisor (r_cfg.up_port_count),
        .o_rsp     (w_hash_rsp)
    );

    ftrc_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_head           (w_head),
        .i_empty          (w_empty),
        .i_hash           (w_hash_rsp),
        .o_pop            (w_pop),
        .o_hash           (w_hash_req),
        .o_valid          (o_valid),
        .o_out_port       (o_out_port),
        .o_hop_count      (o_hop_count),
        .o_last_candidate (o_last_candidate)
    );

    a_burst_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last_candidate |=> o_valid)
        else $error("candidate burst broken before last beat");

    a_hops_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last_candidate |=> o_hop_count == $past(o_hop_count))
        else $error("hop count changed within one packet");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_empty)
        else $error("command queue popped while empty");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result strobe right after reset");

endmodule

FILE: src/ftrc_front.sv
module ftrc_front (
    input  ftrc_pkg::t_cfg i_cfg,
    input  logic           i_start,
    input  logic           i_full,
    input  logic [5:0]     i_arrival_port,
    input  logic [31:0]    i_src_digits,
    input  logic [31:0]    i_dst_digits,
    input  logic [31:0]    i_src_id,
    input  logic [31:0]    i_dst_id,
    output logic           o_busy,
    output logic           o_push,
    output ftrc_pkg::t_cmd o_cmd
);

    logic [3:0]                     w_nl;
    logic [3:0]                     w_lvl;
    logic [ftrc_pkg::LCA_W-1:0]     w_lca;
    logic [3:0]                     w_lca4;
    logic                           w_climb;
    logic [ftrc_pkg::HOP_W-1:0]     w_hops;
    logic [ftrc_pkg::DIGIT_BITS-1:0] w_dig_lvl;
    logic [ftrc_pkg::BASE_W-1:0]    w_leaf_base;
    logic [ftrc_pkg::COUNT_W-1:0]   w_ppt_cnt;
    logic [ftrc_pkg::COUNT_W-1:0]   w_up_cnt;
    logic                           w_has;

    always_comb begin
        w_nl  = (i_cfg.level_count == 4'd0) ? 4'd1 : i_cfg.level_count;
        w_lvl = {1'b0, i_cfg.router_level};
        w_lca = '0;
        for (int i = 0; i < ftrc_pkg::MAX_LEVELS; i++) begin
            if ((4'(i) < w_nl) &&
                (i_src_digits[i*ftrc_pkg::DIGIT_BITS +: ftrc_pkg::DIGIT_BITS] !=
                 i_dst_digits[i*ftrc_pkg::DIGIT_BITS +: ftrc_pkg::DIGIT_BITS])) begin
                w_lca = ftrc_pkg::LCA_W'(i);
            end
        end
        w_lca4 = 4'(w_lca);
    end

    always_comb begin
        w_climb = (w_lvl != w_nl - 4'd1) && (i_arrival_port < i_cfg.down_port_count) &&
                  !(i_cfg.early_turn && (w_lca4 == w_lvl));
        if (w_climb) begin
            if (i_cfg.early_turn) begin
                w_hops = (w_lca4 + 4'd1) + (w_lca4 - w_lvl);
            end else begin
                w_hops = w_nl + w_nl - w_lvl - 4'd1;
            end
        end else begin
            w_hops = w_lvl + 4'd1;
        end
    end

    always_comb begin
        if (w_lvl < 4'(ftrc_pkg::MAX_LEVELS)) begin
            w_dig_lvl = i_dst_digits[i_cfg.router_level[ftrc_pkg::LCA_W-1:0] *
                                     ftrc_pkg::DIGIT_BITS +: ftrc_pkg::DIGIT_BITS];
        end else begin
            w_dig_lvl = '0;
        end
        w_leaf_base =
            {{(ftrc_pkg::BASE_W-ftrc_pkg::DIGIT_BITS){1'b0}},
             i_dst_digits[ftrc_pkg::DIGIT_BITS-1:0]} *
            {{(ftrc_pkg::BASE_W-6){1'b0}}, i_cfg.ports_per_terminal};
        w_ppt_cnt = (i_cfg.ports_per_terminal > 6'(ftrc_pkg::MAX_CANDS)) ?
                    6'(ftrc_pkg::MAX_CANDS) : i_cfg.ports_per_terminal;
        w_up_cnt  = (i_cfg.up_port_count > 6'(ftrc_pkg::MAX_CANDS)) ?
                    6'(ftrc_pkg::MAX_CANDS) : i_cfg.up_port_count;
    end

    always_comb begin
        o_cmd.hops   = w_hops;
        o_cmd.src_id = i_src_id;
        o_cmd.dst_id = i_dst_id;
        if (!w_climb) begin
            o_cmd.kind = ftrc_pkg::K_RANGE;
            if (i_cfg.router_level == 3'd0) begin
                o_cmd.base  = w_leaf_base;
                o_cmd.count = w_ppt_cnt;
                w_has       = (i_cfg.ports_per_terminal != 6'd0);
            end else begin
                o_cmd.base  = ftrc_pkg::BASE_W'(w_dig_lvl);
                o_cmd.count = 6'd1;
                w_has       = 1'b1;
            end
        end else begin
            o_cmd.base = ftrc_pkg::BASE_W'(i_cfg.down_port_count);
            w_has      = (i_cfg.up_port_count != 6'd0);
            if (i_cfg.up_selection) begin
                o_cmd.kind  = ftrc_pkg::K_HASH;
                o_cmd.count = 6'd1;
            end else begin
                o_cmd.kind  = ftrc_pkg::K_RANGE;
                o_cmd.count = w_up_cnt;
            end
        end
    end

    assign o_busy = i_full;
    assign o_push = i_start && !i_full && w_has;

endmodule

FILE: src/ftrc_queue.sv
module ftrc_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ftrc_pkg::t_cmd i_data,
    input  logic           i_pop,
    output ftrc_pkg::t_cmd o_data,
    output logic           o_full,
    output logic           o_empty
);

    ftrc_pkg::t_cmd              r_mem [0:ftrc_pkg::QUEUE_DEPTH-1];
    logic [ftrc_pkg::QPTR_W-1:0] r_wr_ptr;
    logic [ftrc_pkg::QPTR_W-1:0] r_rd_ptr;
    logic [ftrc_pkg::QPTR_W:0]   r_count;

    assign o_full  = (r_count == (ftrc_pkg::QPTR_W+1)'(ftrc_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

FILE: src/ftrc_hash.sv
module ftrc_hash (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ftrc_pkg::t_hash_req i_req,
    input  logic [31:0]         i_seed,
    input  logic [5:0]          i_divisor,
    output ftrc_pkg::t_hash_rsp o_rsp
);

    ftrc_pkg::t_hash_state r_state;
    ftrc_pkg::t_hash_state n_state;
    logic [31:0]           r_a;
    logic [31:0]           r_b;
    logic [31:0]           r_c;
    logic [31:0]           n_a;
    logic [31:0]           n_b;
    logic [31:0]           n_c;
    logic [31:0]           r_sid;
    logic [31:0]           r_did;
    logic [2:0]            r_round;
    logic [1:0]            r_step;
    logic [5:0]            r_rem;
    logic [5:0]            n_rem;

    function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] k);
        rotl = (x << k) | (x >> (6'd32 - {1'b0, k}));
    endfunction

    always_comb begin
        n_a = r_a;
        n_b = r_b;
        n_c = r_c;
        unique case (r_round)
            3'd0:    n_c = (r_c ^ r_b) - rotl(r_b, ftrc_pkg::HASH_ROT[0]);
            3'd1:    n_a = (r_a ^ r_c) - rotl(r_c, ftrc_pkg::HASH_ROT[1]);
            3'd2:    n_b = (r_b ^ r_a) - rotl(r_a, ftrc_pkg::HASH_ROT[2]);
            3'd3:    n_c = (r_c ^ r_b) - rotl(r_b, ftrc_pkg::HASH_ROT[3]);
            3'd4:    n_a = (r_a ^ r_c) - rotl(r_c, ftrc_pkg::HASH_ROT[4]);
            3'd5:    n_b = (r_b ^ r_a) - rotl(r_a, ftrc_pkg::HASH_ROT[5]);
            3'd6:    n_c = (r_c ^ r_b) - rotl(r_b, ftrc_pkg::HASH_ROT[6]);
            default: n_c = r_c;
        endcase
    end

    always_comb begin
        logic [6:0] v_rem;
        v_rem = {1'b0, r_rem};
        for (int j = 0; j < ftrc_pkg::MOD_BITS; j++) begin
            v_rem = {v_rem[5:0], r_c[31-j]};
            if (v_rem >= {1'b0, i_divisor}) begin
                v_rem = v_rem - {1'b0, i_divisor};
            end
        end
        n_rem = v_rem[5:0];
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ftrc_pkg::H_IDLE: begin
                if (i_req.start) begin
                    n_state = ftrc_pkg::H_LOAD;
                end
            end
            ftrc_pkg::H_LOAD: n_state = ftrc_pkg::H_MIX;
            ftrc_pkg::H_MIX: begin
                if (r_round == 3'(ftrc_pkg::MIX_ROUNDS - 1)) begin
                    n_state = ftrc_pkg::H_MOD;
                end
            end
            ftrc_pkg::H_MOD: begin
                if (r_step == 2'(ftrc_pkg::MOD_STEPS - 1)) begin
                    n_state = i_req.start ? ftrc_pkg::H_LOAD : ftrc_pkg::H_IDLE;
                end
            end
            default: n_state = ftrc_pkg::H_IDLE;
        endcase
    end

    always_comb begin
        o_rsp.done = (r_state == ftrc_pkg::H_MOD) &&
                     (r_step == 2'(ftrc_pkg::MOD_STEPS - 1));
        o_rsp.rem  = n_rem;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ftrc_pkg::H_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_sid <= i_req.src_id;
            r_did <= i_req.dst_id;
            r_c   <= ftrc_pkg::HASH_INIT + i_seed;
        end else begin
            unique case (r_state)
                ftrc_pkg::H_LOAD: begin
                    r_a     <= r_c + r_did;
                    r_b     <= r_c + r_sid;
                    r_round <= '0;
                end
                ftrc_pkg::H_MIX: begin
                    r_a     <= n_a;
                    r_b     <= n_b;
                    r_c     <= n_c;
                    r_round <= r_round + 3'd1;
                    r_rem   <= '0;
                    r_step  <= '0;
                end
                ftrc_pkg::H_MOD: begin
                    r_c    <= r_c << ftrc_pkg::MOD_BITS;
                    r_rem  <= n_rem;
                    r_step <= r_step + 2'd1;
                end
                default: begin
                    r_step <= r_step;
                end
            endcase
        end
    end

endmodule

FILE: src/ftrc_back.sv
module ftrc_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  ftrc_pkg::t_cmd             i_head,
    input  logic                       i_empty,
    input  ftrc_pkg::t_hash_rsp        i_hash,
    output logic                       o_pop,
    output ftrc_pkg::t_hash_req        o_hash,
    output logic                       o_valid,
    output logic [ftrc_pkg::PORT_W-1:0] o_out_port,
    output logic [ftrc_pkg::HOP_W-1:0]  o_hop_count,
    output logic                       o_last_candidate
);

    ftrc_pkg::t_back_state       r_state;
    ftrc_pkg::t_back_state       n_state;
    ftrc_pkg::t_cmd              r_cmd;
    logic [ftrc_pkg::IDX_W-1:0]  r_idx;
    logic                        r_valid;
    logic                        n_valid;
    logic [ftrc_pkg::PORT_W-1:0] r_port;
    logic [ftrc_pkg::PORT_W-1:0] n_port;
    logic [ftrc_pkg::HOP_W-1:0]  r_hops;
    logic                        r_last;
    logic                        n_last;
    logic                        w_emit_last;
    logic                        w_free;
    logic                        w_load;
    logic [ftrc_pkg::BASE_W-1:0] w_sum;

    function automatic logic [ftrc_pkg::PORT_W-1:0] clamp_port(
        input logic [ftrc_pkg::BASE_W-1:0] p
    );
        clamp_port = (p > ftrc_pkg::BASE_W'(ftrc_pkg::PORT_MAX)) ?
                     ftrc_pkg::PORT_W'(ftrc_pkg::PORT_MAX) : p[ftrc_pkg::PORT_W-1:0];
    endfunction

    assign w_emit_last = ({1'b0, r_idx} == r_cmd.count - 6'd1);
    assign w_free = (r_state == ftrc_pkg::B_IDLE) ||
                    ((r_state == ftrc_pkg::B_EMIT) && w_emit_last) ||
                    ((r_state == ftrc_pkg::B_HASH) && i_hash.done);
    assign w_load = w_free && !i_empty;

    always_comb begin
        n_state = r_state;
        if (w_free) begin
            if (i_empty) begin
                n_state = ftrc_pkg::B_IDLE;
            end else if (i_head.kind == ftrc_pkg::K_HASH) begin
                n_state = ftrc_pkg::B_HASH;
            end else begin
                n_state = ftrc_pkg::B_EMIT;
            end
        end
    end

    always_comb begin
        o_pop         = w_load;
        o_hash.start  = w_load && (i_head.kind == ftrc_pkg::K_HASH);
        o_hash.src_id = i_head.src_id;
        o_hash.dst_id = i_head.dst_id;
        n_valid       = 1'b0;
        n_last        = 1'b0;
        w_sum         = r_cmd.base + ftrc_pkg::BASE_W'(r_idx);
        unique case (r_state)
            ftrc_pkg::B_EMIT: begin
                n_valid = 1'b1;
                n_last  = w_emit_last;
            end
            ftrc_pkg::B_HASH: begin
                w_sum   = r_cmd.base + ftrc_pkg::BASE_W'(i_hash.rem);
                n_valid = i_hash.done;
                n_last  = 1'b1;
            end
            default: begin
                n_valid = 1'b0;
            end
        endcase
        n_port = clamp_port(w_sum);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ftrc_pkg::B_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_cmd <= i_head;
            r_idx <= '0;
        end else if (r_state == ftrc_pkg::B_EMIT) begin
            r_idx <= r_idx + 1'b1;
        end
        r_port <= n_port;
        r_hops <= r_cmd.hops;
        r_last <= n_last;
    end

    assign o_valid          = r_valid;
    assign o_out_port       = r_port;
    assign o_hop_count      = r_hops;
    assign o_last_candidate = r_last;

endmodule
